FILE: hdl/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants of the key chord detector: field widths,
// chord phases, the request and result items and the pressed map write bus.
// ----------------------------------------------------------------------------
package kcd_pkg;

   // sizes
   localparam int KEY_CODES  = 256;
   localparam int CODE_W     = $clog2(KEY_CODES);
   localparam int CHORD_KEYS = 32;
   localparam int IDX_W      = 5;
   localparam int CNT_W      = $clog2(KEY_CODES + 1);
   localparam int NKEY_W     = $clog2(CHORD_KEYS + 1);
   localparam int TIME_W     = 32;
   localparam int PHASE_W    = 3;

   localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(50000);

   // stream payload widths (padded to whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // chord phases
   typedef enum logic [PHASE_W-1:0] {
      PH_NEW        = 3'd0,
      PH_CHORDING   = 3'd1,
      PH_UNCHORDING = 3'd2,
      PH_CANCELLED  = 3'd3,
      PH_COMPLETED  = 3'd4
   } phase_type;

   // request operation codes
   localparam logic OP_KEY   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // one input item
   typedef struct packed {
      logic                    op;
      logic [CODE_W-1:0]       key_code;
      logic [IDX_W-1:0]        steno_index;
      logic                    key_down;
      logic [TIME_W-1:0]       timestamp;
   } req_type;

   // one result item
   typedef struct packed {
      phase_type               phase;
      logic [CHORD_KEYS-1:0]   chord_keys;
      logic                    constructing;
      logic                    recorded;
   } rsp_type;

   // pressed map write / clear command
   typedef struct packed {
      logic                    en;
      logic                    clr;
      logic [CODE_W-1:0]       addr;
      logic                    data;
   } map_wr_type;

endpackage

FILE: hdl/kcd_pressed_ram.sv
// ----------------------------------------------------------------------------
// kcd_pressed_ram
// Pressed key map: one bit per key code in a synchronous RAM, with a
// per-entry valid vector cleared at once on reset and on a chord clear.
// Read data is registered; a write or clear in the read cycle is forwarded.
// ----------------------------------------------------------------------------
module kcd_pressed_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [kcd_pkg::CODE_W-1:0] rd_addr,
   input  kcd_pkg::map_wr_type        wr,
   output logic                      rd_pressed
);

   logic                           pressed_mem [kcd_pkg::KEY_CODES];
   logic [kcd_pkg::KEY_CODES-1:0]  vld_ff;
   logic                           rd_mem_ff;
   logic                           rd_vld_ff;
   logic                           fwd_hit_ff;
   logic                           fwd_val_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         pressed_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_mem_ff <= pressed_mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
         fwd_val_ff <= wr.clr ? 1'b0 : wr.data;
      end
   end

   // entry valid bits: not valid reads as not pressed
   always_ff @(posedge clock) begin
      if (reset || wr.clr) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // forward an update landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr.clr || (wr.en && (wr.addr == rd_addr));
      end
   end

   assign rd_pressed = fwd_hit_ff ? fwd_val_ff : (rd_vld_ff & rd_mem_ff);

endmodule

FILE: hdl/kcd_chord_core.sv
// ----------------------------------------------------------------------------
// kcd_chord_core
// Chord state and update logic: phase, pressed count, chord mask and key
// count, key-down times. Works on the item whose map bit has been read and
// issues the write back to the pressed map.
// ----------------------------------------------------------------------------
module kcd_chord_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  kcd_pkg::req_type            item,
   input  logic                        pressed,
   input  logic [kcd_pkg::TIME_W-1:0]  window,
   output kcd_pkg::map_wr_type         map_wr,
   output kcd_pkg::rsp_type            result
);

   kcd_pkg::phase_type                 phase_ff, phase_in;
   logic [kcd_pkg::CNT_W-1:0]          pcount_ff, pcount_in;
   logic [kcd_pkg::CHORD_KEYS-1:0]     mask_ff, mask_in;
   logic [kcd_pkg::NKEY_W-1:0]         nkeys_ff, nkeys_in;
   logic [kcd_pkg::TIME_W-1:0]         first_ff, first_in;
   logic [kcd_pkg::TIME_W-1:0]         last_ff, last_in;
   logic [kcd_pkg::TIME_W-1:0]         span;
   logic                               in_chord;
   logic                               wr_en;
   logic                               wr_data;
   logic                               rec;

   // key-down spacing, modulo 2^32
   assign span     = last_ff - first_ff;
   assign in_chord = (phase_ff == kcd_pkg::PH_CHORDING) ||
                     (phase_ff == kcd_pkg::PH_UNCHORDING);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      mask_in   = mask_ff;
      nkeys_in  = nkeys_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_data   = 1'b0;
      rec       = 1'b0;
      if (item.op == kcd_pkg::OP_CLEAR) begin
         phase_in  = kcd_pkg::PH_NEW;
         pcount_in = '0;
         mask_in   = '0;
         nkeys_in  = '0;
         first_in  = '0;
         last_in   = '0;
      end else if (item.key_down) begin
         rec = !pressed;
         if (in_chord || (phase_ff == kcd_pkg::PH_NEW)) begin
            if (phase_ff == kcd_pkg::PH_NEW) begin
               phase_in = kcd_pkg::PH_CHORDING;
               first_in = item.timestamp;
            end
            // new chord key
            if (!mask_ff[item.steno_index]) begin
               mask_in[item.steno_index] = 1'b1;
               nkeys_in = nkeys_ff + kcd_pkg::NKEY_W'(1);
            end
            if (!pressed) begin
               wr_en     = 1'b1;
               wr_data   = 1'b1;
               pcount_in = pcount_ff + kcd_pkg::CNT_W'(1);
            end
            last_in = item.timestamp;
         end
      end else begin
         rec = 1'b1;
         if (in_chord) begin
            phase_in = kcd_pkg::PH_UNCHORDING;
            if (pressed) begin
               wr_en     = 1'b1;
               pcount_in = pcount_ff - kcd_pkg::CNT_W'(1);
            end
            // all keys up: judge the chord
            if (pcount_in == '0) begin
               if (nkeys_ff < kcd_pkg::NKEY_W'(2)) begin
                  phase_in = kcd_pkg::PH_CANCELLED;
               end else if (nkeys_ff == kcd_pkg::NKEY_W'(2)) begin
                  phase_in = (span < window) ? kcd_pkg::PH_COMPLETED
                                             : kcd_pkg::PH_CANCELLED;
               end else begin
                  phase_in = kcd_pkg::PH_COMPLETED;
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= kcd_pkg::PH_NEW;
         pcount_ff <= '0;
         mask_ff   <= '0;
         nkeys_ff  <= '0;
         first_ff  <= '0;
         last_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         mask_ff   <= mask_in;
         nkeys_ff  <= nkeys_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
      end
   end

   // write back to the pressed map
   assign map_wr.en   = fire && wr_en;
   assign map_wr.clr  = fire && (item.op == kcd_pkg::OP_CLEAR);
   assign map_wr.addr = item.key_code;
   assign map_wr.data = wr_data;

   // result item
   assign result.phase        = phase_in;
   assign result.chord_keys   = mask_in;
   assign result.constructing = (phase_in == kcd_pkg::PH_CHORDING) ||
                                (phase_in == kcd_pkg::PH_UNCHORDING);
   assign result.recorded     = rec;

   // keys held only while a chord is being built
   a_held_in_chord: assert property (@(posedge clock) disable iff (reset)
      (pcount_ff != '0) |-> in_chord)
      else $error("keys held outside a chord");

   // key count tracks the mask
   a_nkeys_match: assert property (@(posedge clock) disable iff (reset)
      nkeys_ff == kcd_pkg::NKEY_W'($countones(mask_ff)))
      else $error("chord key count out of step with mask");

   // a finished chord never touches the map
   a_no_write_done: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == kcd_pkg::PH_CANCELLED || phase_ff == kcd_pkg::PH_COMPLETED)
      |-> !map_wr.en)
      else $error("map write after chord end");

endmodule

FILE: hdl/key_chord_detector_core.sv
// ----------------------------------------------------------------------------
// key_chord_detector_core
// Key chord detector: tracks one chord from keyboard events, keeping the
// pressed key map in RAM and the chord state in registers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per accepted handshake: a key event (code, chord
//   key index, down/up, timestamp) or, with req_tuser high, a chord clear.
//   rsp_* returns exactly one item per request: phase, chord key mask,
//   constructing flag and recorded flag.
//   csr_we / csr_wdata load the two-key window; write only while idle.
// Pipeline: the accepting edge reads the pressed map RAM; the edge on which
//   the update stage fires updates the chord state, writes the map back and
//   loads the result. Same-key writes on a read edge are forwarded.
// Throughput: one item per cycle while rsp_tready is high.
// Reset: chord returns to phase new, all keys read as released at once
//   (per-entry valid bits), window returns to 50000 ticks.
// Stall: the result sits in the output register; one item waits in the
//   update stage and further requests are held off with req_tready low.
// ----------------------------------------------------------------------------
module key_chord_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   // request: [7:0] key_code, [12:8] steno_index, [13] key_down,
   //          [45:14] timestamp, [47:46] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,   // [0] op
   // result: [2:0] phase, [34:3] chord_keys, [35] constructing,
   //         [36] recorded, [39:37] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kcd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // two-key window register
   input  logic                               csr_we,
   input  logic [kcd_pkg::TIME_W-1:0]         csr_wdata
);

   kcd_pkg::req_type                 req_item;
   kcd_pkg::req_type                 s1_item_ff;
   logic                             s1_valid_ff;
   logic                             s1_fire;
   logic                             accept;
   logic                             pressed;
   kcd_pkg::map_wr_type              map_wr;
   kcd_pkg::rsp_type                 result;
   kcd_pkg::rsp_type                 rsp_item_ff;
   logic                             rsp_valid_ff;
   logic [kcd_pkg::TIME_W-1:0]       window_ff;

   // unpack request
   assign req_item.op          = req_tuser;
   assign req_item.key_code    = req_tdata[7:0];
   assign req_item.steno_index = req_tdata[12:8];
   assign req_item.key_down    = req_tdata[13];
   assign req_item.timestamp   = req_tdata[45:14];

   // handshake
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   // window register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= kcd_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         window_ff <= csr_wdata;
      end
   end

   // update stage: item waits here while its map bit is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   kcd_pressed_ram u_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_item.key_code),
      .wr         (map_wr),
      .rd_pressed (pressed)
   );

   kcd_chord_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item_ff),
      .pressed(pressed),
      .window (window_ff),
      .map_wr (map_wr),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_item_ff.recorded, rsp_item_ff.constructing,
                        rsp_item_ff.chord_keys, rsp_item_ff.phase};

   // a clear yields an empty, unrecorded chord in phase new
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_item_ff.op == kcd_pkg::OP_CLEAR)) |=>
      (rsp_tdata[2:0] == kcd_pkg::PH_NEW && rsp_tdata[34:3] == '0 && !rsp_tdata[36]))
      else $error("clear result not empty");

   // constructing flag agrees with the phase
   a_constructing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[35] ==
         (rsp_tdata[2:0] == kcd_pkg::PH_CHORDING ||
          rsp_tdata[2:0] == kcd_pkg::PH_UNCHORDING)))
      else $error("constructing flag mismatch");

   // an item entering the update stage never overwrites a waiting one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |-> !accept)
      else $error("update stage overrun");

endmodule
